// ===== rtl/lbs4_pkg.sv =====
// shared constants, types and codes for the four-influence skinning unit
package lbs4_pkg;

    // joint palette geometry
    localparam int NumJoints     = 256;
    localparam int ElemsPerJoint = 12;
    localparam int Influences    = 4;
    localparam int JointAw       = $clog2(NumJoints);

    // weight sum window, scaled by 100 to stay in integers
    localparam int WsumLowX100  = 99 * 65536;
    localparam int WsumHighX100 = 101 * 65536;

    // divider layout: quotient bits resolved per stage and stage count
    localparam int DivBits   = 4;
    localparam int DivStages = 32 / DivBits;

    // word kinds carried on the input tuser
    typedef enum logic {
        CMD_SKIN = 1'b0,
        CMD_LOAD = 1'b1
    } t_cmd;

    // one multi-bit step of the restoring divider
    typedef struct packed {
        logic [18:0]        rem;
        logic [DivBits-1:0] q;
    } t_div_step;

endpackage

// ===== rtl/linear_blend_skinning_4.sv =====
// four-influence linear blend skinning pipeline with joint palette banks
// the pipeline stalls on output back-pressure; bubbles collapse
// throughput: one word per cycle while not stalled; palette banks read one joint per bank per cycle
// load words write one palette element at acceptance and give no result
// reset clears pipeline valid bits only; palette contents stay undefined until written
// divider resolves four quotient bits per stage over eight stages
module linear_blend_skinning_4 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x, pos_y, pos_z, weight_a..weight_d, joint_a..joint_d
    input  logic [191:0] i_s_tdata,
    // cmd
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_x, out_y, out_z
    output logic [95:0]  o_m_tdata,
    // weight_sum_bad
    output logic         o_m_tuser
);

    localparam int NInf   = lbs4_pkg::Influences;
    localparam int NElem  = lbs4_pkg::ElemsPerJoint;
    localparam int NDiv   = lbs4_pkg::DivStages;
    localparam int DBits  = lbs4_pkg::DivBits;
    localparam int SPrep  = 6;
    localparam int Ns     = SPrep + NDiv + 2;
    localparam int SOut   = Ns - 1;

    // stage handshake
    logic [Ns:0]   s_rdy;
    logic [Ns-1:0] r_vld;
    logic          s_acc;
    logic          s_load;
    logic          s_wr;

    // input unpacking
    logic signed [31:0]        s_pos [3];
    logic [15:0]               s_w   [NInf];
    logic [7:0]                s_j   [NInf];
    logic [lbs4_pkg::JointAw-1:0] s_addr [NInf];
    logic [17:0]               n_wsum;
    logic [24:0]               n_x100;

    // stage 0: palette read
    logic [31:0]        s0_mat [NInf][NElem];
    logic signed [31:0] r0_pos [3];
    logic [15:0]        r0_w   [NInf];
    logic [NInf-1:0]    r0_inr;
    logic [17:0]        r0_wsum;
    logic               r0_bad;

    // stage 1: products
    logic signed [63:0] r1_prod [NInf][3][3];
    logic signed [31:0] r1_m3   [NInf][3];
    logic [15:0]        r1_w    [NInf];
    logic [NInf-1:0]    r1_inr;
    logic [17:0]        r1_wsum;
    logic               r1_bad;

    // stage 2: row sums
    logic signed [65:0] r2_sum [NInf][3];
    logic signed [31:0] r2_m3  [NInf][3];
    logic [15:0]        r2_w   [NInf];
    logic [NInf-1:0]    r2_inr;
    logic [17:0]        r2_wsum;
    logic               r2_bad;

    // stage 3: transformed points
    logic signed [50:0] n3_t   [NInf][3];
    logic signed [31:0] n3_row [NInf][3];
    logic signed [31:0] r3_row [NInf][3];
    logic [15:0]        r3_w   [NInf];
    logic [17:0]        r3_wsum;
    logic               r3_bad;

    // stage 4: weighted points
    logic signed [48:0] r4_pw [NInf][3];
    logic [17:0]        r4_wsum;
    logic               r4_bad;

    // stage 5: blend sums
    logic signed [50:0] r5_acc [3];
    logic [17:0]        r5_wsum;
    logic               r5_bad;

    // stage 6 and divider stages
    logic [50:0]        n6_abs [3];
    logic [50:0]        n6_num [3];
    logic [18:0]        n6_dvs;
    logic [18:0]        r_rem  [NDiv+1][3];
    logic [31:0]        r_lo   [NDiv+1][3];
    logic [31:0]        r_q    [NDiv+1][3];
    logic [2:0]         r_neg  [NDiv+1];
    logic [2:0]         r_ovf  [NDiv+1];
    logic [18:0]        r_dvs  [NDiv+1];
    logic               r_zero [NDiv+1];
    logic               r_bad  [NDiv+1];
    lbs4_pkg::t_div_step n_div [NDiv+1][3];

    // output stage
    logic [31:0] n_out [3];
    logic [31:0] r_out [3];
    logic        r_out_bad;

    // one quotient digit group of the restoring divider
    function automatic lbs4_pkg::t_div_step f_div_step(
        input logic [18:0]       rem,
        input logic [DBits-1:0]  bits,
        input logic [18:0]       dvs
    );
        lbs4_pkg::t_div_step res;
        logic [19:0]         t;
        res.rem = rem;
        res.q   = '0;
        for (int k = DBits - 1; k >= 0; k--) begin
            t = {res.rem, bits[k]};
            if (t >= {1'b0, dvs}) begin
                t        = t - {1'b0, dvs};
                res.q[k] = 1'b1;
            end
            res.rem = t[18:0];
        end
        return res;
    endfunction

    // ready ripples back from the output; bubbles collapse
    always_comb begin
        s_rdy[Ns] = i_m_tready;
        for (int k = Ns - 1; k >= 0; k--) begin
            s_rdy[k] = !r_vld[k] || s_rdy[k+1];
        end
    end

    assign o_s_tready = s_rdy[0];
    assign s_acc      = i_s_tvalid && s_rdy[0];
    assign s_load     = (lbs4_pkg::t_cmd'(i_s_tuser) == lbs4_pkg::CMD_LOAD);
    assign s_wr       = s_acc && s_load
                        && (int'(i_s_tdata[167:160]) < lbs4_pkg::NumJoints)
                        && (int'(i_s_tdata[175:168]) < NElem);

    // unpack input word
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s_pos[c] = $signed(i_s_tdata[32*c +: 32]);
        end
        for (int i = 0; i < NInf; i++) begin
            s_w[i]    = i_s_tdata[96 + 16*i +: 16];
            s_j[i]    = i_s_tdata[160 + 8*i +: 8];
            s_addr[i] = lbs4_pkg::JointAw'(s_j[i]);
        end
        n_wsum = 18'(s_w[0]) + 18'(s_w[1]) + 18'(s_w[2]) + 18'(s_w[3]);
        n_x100 = 25'(n_wsum) * 25'(100);
    end

    // palette banks: one per influence and element; a load writes the addressed element in every influence bank
    for (genvar gi = 0; gi < NInf; gi++) begin : g_inf
        for (genvar ge = 0; ge < NElem; ge++) begin : g_elem
            logic [31:0] mem [lbs4_pkg::NumJoints];
            logic [31:0] r_rd;

            always_ff @(posedge i_clk) begin
                if (s_wr && (i_s_tdata[175:168] == 8'(ge))) begin
                    mem[lbs4_pkg::JointAw'(i_s_tdata[167:160])] <= i_s_tdata[31:0];
                end
                if (s_rdy[0]) begin
                    r_rd <= mem[s_addr[gi]];
                end
            end

            assign s0_mat[gi][ge] = r_rd;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (s_rdy[0]) begin
                r_vld[0] <= s_acc && !s_load;
            end
            for (int k = 1; k < Ns; k++) begin
                if (s_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0 sideband
    always_ff @(posedge i_clk) begin
        if (s_rdy[0]) begin
            r0_pos  <= s_pos;
            r0_w    <= s_w;
            for (int i = 0; i < NInf; i++) begin
                r0_inr[i] <= int'(s_j[i]) < lbs4_pkg::NumJoints;
            end
            r0_wsum <= n_wsum;
            r0_bad  <= !((n_x100 > 25'(lbs4_pkg::WsumLowX100))
                         && (n_x100 < 25'(lbs4_pkg::WsumHighX100)));
        end
    end

    // stage 1: matrix times position
    always_ff @(posedge i_clk) begin
        if (s_rdy[1]) begin
            for (int i = 0; i < NInf; i++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r1_prod[i][r][c] <= $signed(s0_mat[i][r*4+c]) * r0_pos[c];
                    end
                    r1_m3[i][r] <= $signed(s0_mat[i][r*4+3]);
                end
            end
            r1_w    <= r0_w;
            r1_inr  <= r0_inr;
            r1_wsum <= r0_wsum;
            r1_bad  <= r0_bad;
        end
    end

    // stage 2: row sums with half-lsb rounding term
    always_ff @(posedge i_clk) begin
        if (s_rdy[2]) begin
            for (int i = 0; i < NInf; i++) begin
                for (int r = 0; r < 3; r++) begin
                    r2_sum[i][r] <= 66'(r1_prod[i][r][0]) + 66'(r1_prod[i][r][1])
                                    + 66'(r1_prod[i][r][2]) + 66'sd32768;
                end
            end
            r2_m3   <= r1_m3;
            r2_w    <= r1_w;
            r2_inr  <= r1_inr;
            r2_wsum <= r1_wsum;
            r2_bad  <= r1_bad;
        end
    end

    // stage 3: scale down, add translation, saturate; out-of-range joints give zero
    always_comb begin
        for (int i = 0; i < NInf; i++) begin
            for (int r = 0; r < 3; r++) begin
                n3_t[i][r] = 51'(r2_sum[i][r] >>> 16) + 51'(r2_m3[i][r]);
                if (!r2_inr[i]) begin
                    n3_row[i][r] = '0;
                end else if (n3_t[i][r] > 51'sd2147483647) begin
                    n3_row[i][r] = 32'sh7fff_ffff;
                end else if (n3_t[i][r] < -51'sd2147483648) begin
                    n3_row[i][r] = 32'sh8000_0000;
                end else begin
                    n3_row[i][r] = 32'(n3_t[i][r]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[3]) begin
            r3_row  <= n3_row;
            r3_w    <= r2_w;
            r3_wsum <= r2_wsum;
            r3_bad  <= r2_bad;
        end
    end

    // stage 4: weight each point
    always_ff @(posedge i_clk) begin
        if (s_rdy[4]) begin
            for (int i = 0; i < NInf; i++) begin
                for (int r = 0; r < 3; r++) begin
                    r4_pw[i][r] <= r3_row[i][r] * $signed({1'b0, r3_w[i]});
                end
            end
            r4_wsum <= r3_wsum;
            r4_bad  <= r3_bad;
        end
    end

    // stage 5: blend
    always_ff @(posedge i_clk) begin
        if (s_rdy[5]) begin
            for (int r = 0; r < 3; r++) begin
                r5_acc[r] <= 51'(r4_pw[0][r]) + 51'(r4_pw[1][r])
                             + 51'(r4_pw[2][r]) + 51'(r4_pw[3][r]);
            end
            r5_wsum <= r4_wsum;
            r5_bad  <= r4_bad;
        end
    end

    // stage 6: magnitude, rounded dividend, overflow check
    always_comb begin
        n6_dvs = {r5_wsum, 1'b0};
        for (int r = 0; r < 3; r++) begin
            n6_abs[r] = r5_acc[r][50] ? 51'(-r5_acc[r]) : 51'(r5_acc[r]);
            n6_num[r] = {n6_abs[r][49:0], 1'b0} + 51'(r5_wsum);
        end
    end

    // divider steps
    always_comb begin
        for (int d = 0; d <= NDiv; d++) begin
            for (int r = 0; r < 3; r++) begin
                n_div[d][r] = f_div_step(r_rem[d][r], r_lo[d][r][31 -: DBits], r_dvs[d]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[SPrep]) begin
            for (int r = 0; r < 3; r++) begin
                r_rem[0][r] <= n6_num[r][50:32];
                r_lo[0][r]  <= n6_num[r][31:0];
                r_q[0][r]   <= '0;
                r_neg[0][r] <= r5_acc[r][50];
                r_ovf[0][r] <= n6_num[r][50:32] >= n6_dvs;
            end
            r_dvs[0]  <= n6_dvs;
            r_zero[0] <= (r5_wsum == '0);
            r_bad[0]  <= r5_bad;
        end
        for (int d = 1; d <= NDiv; d++) begin
            if (s_rdy[SPrep + d]) begin
                for (int r = 0; r < 3; r++) begin
                    r_rem[d][r] <= n_div[d-1][r].rem;
                    r_lo[d][r]  <= {r_lo[d-1][r][31-DBits:0], DBits'(0)};
                    r_q[d][r]   <= {r_q[d-1][r][31-DBits:0], n_div[d-1][r].q};
                end
                r_neg[d]  <= r_neg[d-1];
                r_ovf[d]  <= r_ovf[d-1];
                r_dvs[d]  <= r_dvs[d-1];
                r_zero[d] <= r_zero[d-1];
                r_bad[d]  <= r_bad[d-1];
            end
        end
    end

    // output: sign, saturation, zero weight sum
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r_zero[NDiv]) begin
                n_out[r] = '0;
            end else if (r_ovf[NDiv][r]) begin
                n_out[r] = r_neg[NDiv][r] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else if (r_neg[NDiv][r]) begin
                n_out[r] = (r_q[NDiv][r] > 32'h8000_0000) ? 32'h8000_0000
                                                           : 32'(-r_q[NDiv][r]);
            end else begin
                n_out[r] = (r_q[NDiv][r] > 32'h7fff_ffff) ? 32'h7fff_ffff
                                                           : r_q[NDiv][r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rdy[SOut]) begin
            r_out     <= n_out;
            r_out_bad <= r_bad[NDiv];
        end
    end

    assign o_m_tvalid = r_vld[SOut];
    assign o_m_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign o_m_tuser  = r_out_bad;

    // a load word never enters the arithmetic pipeline
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && s_load) |=> !r_vld[0])
        else $error("load word entered pipeline");

    // after the first divider step, the x remainder stays below divisor for in-range quotients
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SPrep + 1] && !r_zero[1] && !r_ovf[1][0]) |-> (r_rem[1][0] < r_dvs[1]))
        else $error("divider remainder out of range");

    // a zero weight sum is always flagged
    a_zero_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SPrep] && r_zero[0]) |-> r_bad[0])
        else $error("zero weight sum not flagged");

endmodule
